// ----- hw/rtl/nfctpq_pkg.sv -----
// Package for the contactless tag presence qualifier.
// Holds the beat types, item and event codes and register indexes.
// No dependencies.
package nfctpq_pkg;

	// Widths fixed by the beat fields.
	localparam int unsigned TIME_W    = 32;
	localparam int unsigned UID_BYTES = 10;
	localparam int unsigned UID_W     = UID_BYTES * 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_W     = 16;

	// Longest UID that is kept; longer lengths saturate to this.
	localparam logic [3:0] MAX_UID_BYTES = 4'd10;

	// Item kinds.
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_READ   = 2'd1;
	localparam logic [1:0] OP_REINIT = 2'd2;
	localparam logic [1:0] OP_AUDIO  = 2'd3;

	// Result events.
	localparam logic [2:0] EV_NONE      = 3'd0;
	localparam logic [2:0] EV_REQ_READ  = 3'd1;
	localparam logic [2:0] EV_REQ_INIT  = 3'd2;
	localparam logic [2:0] EV_CONFIRMED = 3'd3;
	localparam logic [2:0] EV_REMOVED   = 3'd4;
	localparam logic [2:0] EV_RECOVERED = 3'd5;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_POLL_INTERVAL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RECONNECT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD          = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_QUIET         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_STABLE_READS  = 3'd4;

	// Register reset values.
	localparam logic [15:0] POLL_INTERVAL_RST = 16'd90;
	localparam logic [15:0] RECONNECT_RST     = 16'd2000;
	localparam logic [15:0] HOLD_RST          = 16'd700;
	localparam logic [15:0] QUIET_RST         = 16'd1800;
	localparam logic [7:0]  STABLE_READS_RST  = 8'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] now_ms;
		logic        found;
		logic [3:0]  uid_len;
		logic [63:0] uid_low;
		logic [15:0] uid_high;
		logic        init_ok;
	} item_beat_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [3:0]  card_len;
		logic [63:0] card_low;
		logic [15:0] card_high;
	} result_beat_t;

endpackage

// ----- hw/rtl/nfc_tag_presence_qualifier_core.sv -----
// Top level of the contactless tag presence qualifier.
// Uses nfctpq_pkg for beat types, codes and register indexes.
//
//   channel  | direction | handshake            | beat
//   ---------+-----------+----------------------+----------------------
//   item     | in        | item_valid/stall     | item_beat_t
//   result   | out       | result_valid/stall   | result_beat_t
//   cfg      | in        | cfg_we, no wait      | cfg_index, cfg_data
//
// One beat is taken every cycle while item_stall is low; each item gives one result beat
// through the input register, then the update and result register.
// A single state update lies between the two registers.
// Reset clears the state and loads the register reset values.
// A stalled result holds; the input register still takes one more beat,
// after which item_stall rises until the result is taken.
module nfc_tag_presence_qualifier_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  nfctpq_pkg::item_beat_t    item,
	output logic                      result_valid,
	input  logic                      result_stall,
	output nfctpq_pkg::result_beat_t  result,
	input  logic                      cfg_we,
	input  logic [nfctpq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nfctpq_pkg::CFG_W-1:0]     cfg_data
);
	import nfctpq_pkg::*;

	// Configuration registers.
	logic [15:0] poll_interval_q, reconnect_q, hold_q, quiet_q;
	logic [7:0]  stable_reads_q;

	// Qualifier state.
	logic              ready_q;
	logic [TIME_W-1:0] last_poll_q, last_rc_q, quiet_until_q;
	logic              cand_valid_q, pres_valid_q;
	logic [UID_W-1:0]  cand_uid_q, pres_uid_q;
	logic [3:0]        cand_len_q, pres_len_q;
	logic [7:0]        cand_reads_q;
	logic [TIME_W-1:0] cand_seen_q, pres_seen_q;

	// Pipeline registers.
	logic         valid_s1;
	item_beat_t   item_s1;
	logic         valid_s2;
	result_beat_t result_s2;

	logic advance;

	// Next values from the combinational update.
	logic              ready_d;
	logic [TIME_W-1:0] last_poll_d, last_rc_d, quiet_until_d;
	logic              cand_valid_d, pres_valid_d;
	logic [UID_W-1:0]  cand_uid_d, pres_uid_d;
	logic [3:0]        cand_len_d, pres_len_d;
	logic [7:0]        cand_reads_d;
	logic [TIME_W-1:0] cand_seen_d, pres_seen_d;
	result_beat_t      res_d;

	// Intermediate values of the update.
	logic [TIME_W-1:0] now;
	logic [TIME_W-1:0] rc_gap, poll_gap, quiet_gap, cand_gap, pres_gap;
	logic [3:0]        len_sat;
	logic [UID_W-1:0]  uid_raw, uid_m;
	logic              miss, pres_match, cand_match;
	logic [7:0]        reads_next;

	// The item advances when the result register is free or being emptied.
	assign advance    = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall = valid_s1 && !advance;

	assign result_valid = valid_s2;
	assign result       = result_s2;

	// Configuration writes; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			poll_interval_q <= POLL_INTERVAL_RST;
			reconnect_q     <= RECONNECT_RST;
			hold_q          <= HOLD_RST;
			quiet_q         <= QUIET_RST;
			stable_reads_q  <= STABLE_READS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POLL_INTERVAL: poll_interval_q <= cfg_data;
				REG_RECONNECT:     reconnect_q     <= cfg_data;
				REG_HOLD:          hold_q          <= cfg_data;
				REG_QUIET:         quiet_q         <= cfg_data;
				REG_STABLE_READS:  stable_reads_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
	end

	// Time differences, all by wrapping subtraction.
	assign now       = item_s1.now_ms;
	assign rc_gap    = now - last_rc_q;
	assign poll_gap  = now - last_poll_q;
	assign quiet_gap = now - quiet_until_q;
	assign cand_gap  = now - cand_seen_q;
	assign pres_gap  = now - pres_seen_q;

	// UID length saturation and masking of bytes past the length.
	assign len_sat = (item_s1.uid_len > MAX_UID_BYTES) ? MAX_UID_BYTES : item_s1.uid_len;
	assign uid_raw = {item_s1.uid_high, item_s1.uid_low};

	always_comb begin
		for (int i = 0; i < UID_BYTES; i++) begin
			uid_m[i*8 +: 8] = (4'(i) < len_sat) ? uid_raw[i*8 +: 8] : 8'h00;
		end
	end

	assign miss       = !item_s1.found || (len_sat == 4'd0);
	assign pres_match = pres_valid_q && (pres_len_q == len_sat) && (pres_uid_q == uid_m);
	assign cand_match = cand_valid_q && (cand_len_q == len_sat) && (cand_uid_q == uid_m)
		&& (cand_gap <= {16'd0, hold_q});
	assign reads_next = cand_match ? ((cand_reads_q == 8'hFF) ? 8'hFF : cand_reads_q + 8'd1)
		: 8'd1;

	// State update and result for the item in the input register.
	always_comb begin
		ready_d       = ready_q;
		last_poll_d   = last_poll_q;
		last_rc_d     = last_rc_q;
		quiet_until_d = quiet_until_q;
		cand_valid_d  = cand_valid_q;
		cand_uid_d    = cand_uid_q;
		cand_len_d    = cand_len_q;
		cand_reads_d  = cand_reads_q;
		cand_seen_d   = cand_seen_q;
		pres_valid_d  = pres_valid_q;
		pres_uid_d    = pres_uid_q;
		pres_len_d    = pres_len_q;
		pres_seen_d   = pres_seen_q;
		res_d         = '0;
		case (item_s1.op)
			OP_TICK: begin
				if (!ready_q) begin
					if (rc_gap >= {16'd0, reconnect_q}) begin
						last_rc_d       = now;
						res_d.event_res = EV_REQ_INIT;
					end
				end else if (!quiet_gap[TIME_W-1] && (poll_gap >= {16'd0, poll_interval_q})) begin
					last_poll_d     = now;
					res_d.event_res = EV_REQ_READ;
				end
			end
			OP_READ: begin
				if (miss) begin
					// No tag: let a stale candidate or present card lapse.
					if (cand_valid_q && (cand_gap > {16'd0, hold_q})) begin
						cand_valid_d = 1'b0;
						cand_reads_d = 8'd0;
					end
					if (pres_valid_q && (pres_gap > {16'd0, hold_q})) begin
						pres_valid_d    = 1'b0;
						res_d.event_res = EV_REMOVED;
						res_d.card_len  = pres_len_q;
						res_d.card_low  = pres_uid_q[63:0];
						res_d.card_high = pres_uid_q[UID_W-1:64];
					end
				end else begin
					pres_seen_d = now;
					if (pres_match) begin
						// The card already present is seen again.
						cand_valid_d = 1'b0;
						cand_reads_d = 8'd0;
					end else begin
						cand_seen_d = now;
						if (reads_next >= stable_reads_q) begin
							// Confirmed: the card replaces any present one.
							cand_valid_d    = 1'b0;
							cand_reads_d    = 8'd0;
							pres_valid_d    = 1'b1;
							pres_len_d      = len_sat;
							pres_uid_d      = uid_m;
							res_d.event_res = EV_CONFIRMED;
							res_d.card_len  = len_sat;
							res_d.card_low  = uid_m[63:0];
							res_d.card_high = uid_m[UID_W-1:64];
						end else begin
							cand_valid_d = 1'b1;
							cand_len_d   = len_sat;
							cand_uid_d   = uid_m;
							cand_reads_d = reads_next;
						end
					end
				end
			end
			OP_REINIT: begin
				ready_d = item_s1.init_ok;
				if (item_s1.init_ok && !ready_q) begin
					res_d.event_res = EV_RECOVERED;
				end
			end
			default: begin
				quiet_until_d = now + {16'd0, quiet_q};
			end
		endcase
	end

	// State registers, written as each item advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ready_q       <= 1'b0;
			last_poll_q   <= '0;
			last_rc_q     <= '0;
			quiet_until_q <= '0;
			cand_valid_q  <= 1'b0;
			cand_len_q    <= '0;
			cand_reads_q  <= '0;
			cand_seen_q   <= '0;
			pres_valid_q  <= 1'b0;
			pres_len_q    <= '0;
			pres_seen_q   <= '0;
		end else if (advance) begin
			ready_q       <= ready_d;
			last_poll_q   <= last_poll_d;
			last_rc_q     <= last_rc_d;
			quiet_until_q <= quiet_until_d;
			cand_valid_q  <= cand_valid_d;
			cand_len_q    <= cand_len_d;
			cand_reads_q  <= cand_reads_d;
			cand_seen_q   <= cand_seen_d;
			pres_valid_q  <= pres_valid_d;
			pres_len_q    <= pres_len_d;
			pres_seen_q   <= pres_seen_d;
		end
	end

	// UID stores are only read while their valid flag is set.
	always_ff @(posedge clk) begin
		if (advance) begin
			cand_uid_q <= cand_uid_d;
			pres_uid_q <= pres_uid_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= res_d;
		end
	end

endmodule

// ----- hw/rtl/nfctpq_checker.sv -----
// Port-level checks for the contactless tag presence qualifier.
// Uses nfctpq_pkg; bound to nfc_tag_presence_qualifier_core below.
module nfctpq_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      result_valid,
	input logic                      result_stall,
	input nfctpq_pkg::result_beat_t  result
);
	import nfctpq_pkg::*;

	logic card_ev;
	assign card_ev = (result.event_res == EV_CONFIRMED) || (result.event_res == EV_REMOVED);

	// A stalled result beat stays offered and unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result beat changed");

	// Events without a card carry an all-zero card payload.
	a_no_card: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !card_ev |->
		(result.card_len == 4'd0) && (result.card_low == 64'd0) && (result.card_high == 16'd0))
		else $error("card payload on an event without a card");

	// A reported card has a length within the kept range.
	a_card_len: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && card_ev |->
		(result.card_len != 4'd0) && (result.card_len <= MAX_UID_BYTES))
		else $error("reported card length out of range");

	// Bytes eight and nine are zero for a card of eight bytes or less.
	a_card_mask: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && card_ev && (result.card_len <= 4'd8) |-> (result.card_high == 16'd0))
		else $error("UID bytes past the length not masked");

endmodule

bind nfc_tag_presence_qualifier_core nfctpq_checker u_nfctpq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// Testbench for the contactless tag presence qualifier core.
// Holds a cycle-free predictor of the qualifier and checks every result beat against it.
// Depends on nfctpq_pkg and nfc_tag_presence_qualifier_core.

module testbench;
	import nfctpq_pkg::*;

	typedef enum {FLOW, LIGHT, HEAVY, BLOCKS} stall_mode_t;

	logic         clk;
	logic         arst_n;
	logic         item_valid;
	logic         item_stall;
	item_beat_t   item;
	logic         result_valid;
	logic         result_stall;
	result_beat_t result;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// Register copies held by the predictor.
	logic [15:0] set_poll  = POLL_INTERVAL_RST;
	logic [15:0] set_recon = RECONNECT_RST;
	logic [15:0] set_hold  = HOLD_RST;
	logic [15:0] set_hush  = QUIET_RST;
	logic [7:0]  set_need  = STABLE_READS_RST;

	// Reader pacing state.
	logic        rdr_up      = 1'b0;
	logic [31:0] poll_stamp  = '0;
	logic [31:0] recon_stamp = '0;
	logic [31:0] hush_end    = '0;

	// Pending candidate and the card taken as present.
	logic        cnd_live  = 1'b0;
	logic [63:0] cnd_lo    = '0;
	logic [15:0] cnd_hi    = '0;
	logic [3:0]  cnd_len   = '0;
	logic [7:0]  cnd_hits  = '0;
	logic [31:0] cnd_stamp = '0;
	logic        card_live  = 1'b0;
	logic [63:0] card_lo    = '0;
	logic [15:0] card_hi    = '0;
	logic [3:0]  card_n     = '0;
	logic [31:0] card_stamp = '0;

	result_beat_t events_due[$];
	int          items_taken = 0;
	int          events_seen = 0;
	int          fault_count = 0;
	int          burst_left  = 0;
	logic [31:0] wall_ms     = '0;

	nfc_tag_presence_qualifier_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Works out the event for one item and moves the predictor state on.
	function automatic result_beat_t qualify_item(input item_beat_t it);
		result_beat_t r;
		logic [31:0]  now;
		logic [31:0]  since_hush;
		logic [3:0]   len;
		logic [63:0]  lo;
		logic [15:0]  hi;
		r   = '0;
		now = it.now_ms;
		case (it.op)
			OP_TICK: begin
				if (!rdr_up) begin
					if (now - recon_stamp >= 32'(set_recon)) begin
						recon_stamp = now;
						r.event_res = EV_REQ_INIT;
					end
				end else begin
					// The quiet window ends on a signed comparison of the wrapped difference.
					since_hush = now - hush_end;
					if (!since_hush[31] && now - poll_stamp >= 32'(set_poll)) begin
						poll_stamp  = now;
						r.event_res = EV_REQ_READ;
					end
				end
			end
			OP_READ: begin
				len = (it.uid_len > MAX_UID_BYTES) ? MAX_UID_BYTES : it.uid_len;
				if (!it.found || len == 4'd0) begin
					// No tag answered: let a stale candidate or card lapse.
					if (cnd_live && now - cnd_stamp > 32'(set_hold)) begin
						cnd_live = 1'b0;
						cnd_hits = '0;
					end
					if (card_live && now - card_stamp > 32'(set_hold)) begin
						card_live   = 1'b0;
						r.event_res = EV_REMOVED;
						r.card_len  = card_n;
						r.card_low  = card_lo;
						r.card_high = card_hi;
					end
				end else begin
					// Bytes beyond the length never take part in a compare.
					lo = it.uid_low;
					hi = it.uid_high;
					for (int b = 0; b < 8; b++)
						if (b >= len)
							lo[b*8 +: 8] = 8'h00;
					if (len <= 4'd8)
						hi = '0;
					else if (len == 4'd9)
						hi[15:8] = 8'h00;
					card_stamp = now;
					if (card_live && card_n == len && card_lo == lo && card_hi == hi) begin
						cnd_live = 1'b0;
						cnd_hits = '0;
					end else begin
						if (cnd_live && cnd_len == len && cnd_lo == lo && cnd_hi == hi &&
							now - cnd_stamp <= 32'(set_hold)) begin
							if (cnd_hits != 8'hFF)
								cnd_hits++;
						end else begin
							cnd_live = 1'b1;
							cnd_len  = len;
							cnd_lo   = lo;
							cnd_hi   = hi;
							cnd_hits = 8'd1;
						end
						cnd_stamp = now;
						if (cnd_hits >= set_need) begin
							cnd_live    = 1'b0;
							cnd_hits    = '0;
							card_live   = 1'b1;
							card_n      = len;
							card_lo     = lo;
							card_hi     = hi;
							r.event_res = EV_CONFIRMED;
							r.card_len  = len;
							r.card_low  = lo;
							r.card_high = hi;
						end
					end
				end
			end
			OP_REINIT: begin
				if (it.init_ok && !rdr_up)
					r.event_res = EV_RECOVERED;
				rdr_up = it.init_ok;
			end
			default: begin
				hush_end = now + 32'(set_hush);
			end
		endcase
		return r;
	endfunction

	// Checks each result beat against the oldest expectation, then predicts the item taken.
	always @(posedge clk) begin : result_check
		result_beat_t want;
		result_beat_t due;
		if (result_valid && !result_stall) begin
			events_seen++;
			if (events_due.size() == 0) begin
				$error("result beat with nothing expected: event_res %0d", result.event_res);
				fault_count++;
			end else begin
				want = events_due.pop_front();
				if (result.event_res !== want.event_res) begin
					$error("event_res: expected %0d, got %0d", want.event_res, result.event_res);
					fault_count++;
				end
				if (result.card_len !== want.card_len) begin
					$error("card_len: expected %0d, got %0d", want.card_len, result.card_len);
					fault_count++;
				end
				if (result.card_low !== want.card_low) begin
					$error("card_low: expected %h, got %h", want.card_low, result.card_low);
					fault_count++;
				end
				if (result.card_high !== want.card_high) begin
					$error("card_high: expected %h, got %h", want.card_high, result.card_high);
					fault_count++;
				end
			end
		end
		if (item_valid && !item_stall) begin
			due = qualify_item(item);
			events_due = {events_due, due};
		end
	end

	// The receiver switches between random stall modes, each held for a random span.
	initial begin : receiver
		stall_mode_t mode;
		int          left;
		int          block_n;
		result_stall <= 1'b0;
		mode    = FLOW;
		left    = 0;
		block_n = 0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = stall_mode_t'($urandom_range(0, 3));
				left = $urandom_range(50, 400);
			end
			left--;
			case (mode)
				FLOW:  result_stall <= 1'b0;
				LIGHT: result_stall <= ($urandom_range(0, 9) < 3);
				HEAVY: result_stall <= ($urandom_range(0, 9) < 7);
				default: begin
					if (block_n > 0) begin
						block_n--;
						result_stall <= 1'b1;
					end else begin
						result_stall <= 1'b0;
						if ($urandom_range(0, 7) == 0)
							block_n = $urandom_range(5, 20);
					end
				end
			endcase
		end
	end

	// Sends one beat; bursts of random length are separated by random gaps.
	task automatic send_item(input item_beat_t it);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) :
				$urandom_range(1, 30);
		end
		burst_left--;
		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		items_taken++;
	endtask

	// Fields that the item kind does not use carry random values.
	function automatic item_beat_t blank_item(input logic [1:0] op, input logic [31:0] at);
		item_beat_t it;
		it.op       = op;
		it.now_ms   = at;
		it.found    = 1'($urandom);
		it.uid_len  = 4'($urandom);
		it.uid_low  = {$urandom, $urandom};
		it.uid_high = 16'($urandom);
		it.init_ok  = 1'($urandom);
		return it;
	endfunction

	task automatic tick(input logic [31:0] at);
		wall_ms = at;
		send_item(blank_item(OP_TICK, at));
	endtask

	task automatic read_tag(input logic [31:0] at, input logic found, input logic [3:0] len,
		input logic [63:0] lo, input logic [15:0] hi);
		item_beat_t it;
		it          = blank_item(OP_READ, at);
		it.found    = found;
		it.uid_len  = len;
		it.uid_low  = lo;
		it.uid_high = hi;
		wall_ms     = at;
		send_item(it);
	endtask

	task automatic reinit(input logic [31:0] at, input logic ok);
		item_beat_t it;
		it         = blank_item(OP_REINIT, at);
		it.init_ok = ok;
		wall_ms    = at;
		send_item(it);
	endtask

	task automatic audio(input logic [31:0] at);
		wall_ms = at;
		send_item(blank_item(OP_AUDIO, at));
	endtask

	// Drops valid and waits until every beat sent has come back.
	task automatic settle();
		item_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (events_seen < items_taken);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	// Writes all five registers; only called while the core is idle.
	task automatic configure(input logic [15:0] poll, input logic [15:0] recon,
		input logic [15:0] hold, input logic [15:0] hush, input logic [7:0] need);
		write_reg(REG_POLL_INTERVAL, poll);
		write_reg(REG_RECONNECT, recon);
		write_reg(REG_HOLD, hold);
		write_reg(REG_QUIET, hush);
		write_reg(REG_STABLE_READS, {8'h00, need});
		cfg_we <= 1'b0;
		set_poll  = poll;
		set_recon = recon;
		set_hold  = hold;
		set_hush  = hush;
		set_need  = need;
	endtask

	// Re-init pacing, recovery and read pacing around the quiet window.
	task automatic test_reader_recovery();
		tick(32'd0);
		tick(32'd2000);
		reinit(32'd2100, 1'b0);
		tick(32'd3999);
		tick(32'd4000);
		reinit(32'd4001, 1'b1);
		reinit(32'd4002, 1'b1);
		tick(32'd4003);
		tick(32'd4050);
		audio(32'd4100);
		tick(32'd5899);
		tick(32'd5900);
		reinit(32'd5901, 1'b0);
		tick(32'd6001);
		reinit(32'd6002, 1'b1);
	endtask

	// Debounce, masking of unused bytes, length saturation and removal.
	task automatic test_tag_debounce();
		read_tag(32'd7000, 1'b1, 4'd4, 64'hFFEE_DDCC_0403_0201, 16'hBEEF);
		read_tag(32'd7100, 1'b1, 4'd4, 64'h1234_5678_0403_0201, 16'h0000);
		read_tag(32'd7200, 1'b1, 4'd4, 64'h0000_0000_0403_0201, 16'h0000);
		read_tag(32'd7300, 1'b1, 4'd15, '1, '1);
		read_tag(32'd8200, 1'b1, 4'd15, '1, '1);
		read_tag(32'd8300, 1'b1, 4'd10, '1, '1);
		read_tag(32'd8400, 1'b1, 4'd0, '1, '1);
		read_tag(32'd9001, 1'b0, 4'd10, '1, '1);
		read_tag(32'd9002, 1'b0, 4'd10, '1, '1);
		read_tag(32'd9100, 1'b1, 4'd9, 64'h8877_6655_4433_2211, 16'hABCD);
		read_tag(32'd9200, 1'b1, 4'd9, 64'h8877_6655_4433_2211, 16'h77CD);
		read_tag(32'd9300, 1'b1, 4'd8, 64'h8877_6655_4433_2211, 16'h77CD);
	endtask

	// Register extremes, a zero confirm threshold and time wrap-around.
	task automatic test_register_extremes();
		settle();
		configure(16'd1, 16'd1, 16'd1, 16'd0, 8'd0);
		reinit(32'd10000, 1'b0);
		tick(32'd10001);
		tick(32'd10001);
		reinit(32'd10002, 1'b1);
		read_tag(32'd10003, 1'b1, 4'd7, 64'h0102_0304_0506_0708, 16'h5555);
		audio(32'd10004);
		tick(32'd10004);
		read_tag(32'd10006, 1'b0, 4'd0, '0, '0);
		settle();
		configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
		audio(32'hFFFF_FF00);
		tick(32'hFFFF_FFFF);
		tick(32'h0000_FEFF);
		tick(32'h0002_0000);
		audio(32'h1000_0000);
		tick(32'h9001_0000);
	endtask

	// The longest confirm run: 255 matching reads, then the card lapses.
	task automatic test_long_debounce();
		logic [63:0] lo;
		logic [15:0] hi;
		settle();
		configure(POLL_INTERVAL_RST, RECONNECT_RST, 16'hFFFF, QUIET_RST, 8'hFF);
		lo = {$urandom, $urandom};
		hi = 16'($urandom);
		repeat (255) begin
			read_tag(wall_ms + $urandom_range(0, 2000), 1'b1, 4'd7, lo, hi);
			if ($urandom_range(0, 3) == 0)
				tick(wall_ms);
		end
		read_tag(wall_ms + 32'd65536, 1'b0, 4'd7, lo, hi);
	endtask

	// Well-formed traffic around a small set of tags, with some noise.
	task automatic run_traffic(input int count);
		int          r;
		int          k;
		int unsigned h;
		int unsigned p;
		int unsigned c;
		int unsigned step;
		logic [63:0] pool_lo [3];
		logic [15:0] pool_hi [3];
		logic [3:0]  pool_len [3];
		h = set_hold;
		p = set_poll;
		c = set_recon;
		for (int i = 0; i < 3; i++) begin
			pool_lo[i]  = {$urandom, $urandom};
			pool_hi[i]  = 16'($urandom);
			pool_len[i] = ($urandom_range(0, 4) == 0) ? 4'($urandom) :
				4'(3 * $urandom_range(1, 3) + 1);
		end
		repeat (count) begin
			// Time steps are scaled to the current settings, with rare huge jumps.
			r = $urandom_range(0, 9);
			if (r < 4)
				step = $urandom_range(0, 60);
			else if (r < 7)
				step = $urandom_range(0, h + h / 2 + 2);
			else if (r < 9)
				step = $urandom_range(0, 2 * p + 2);
			else if ($urandom_range(0, 15) == 0)
				step = $urandom;
			else
				step = $urandom_range(0, c + 50);
			wall_ms = wall_ms + step;
			r = $urandom_range(0, 99);
			k = $urandom_range(0, 2);
			if (r < 35)
				tick(wall_ms);
			else if (r < 72)
				read_tag(wall_ms, 1'b1, pool_len[k], pool_lo[k], pool_hi[k]);
			else if (r < 80)
				read_tag(wall_ms, 1'b0, 4'($urandom), {$urandom, $urandom}, 16'($urandom));
			else if (r < 88)
				reinit(wall_ms, $urandom_range(0, 7) != 0);
			else if (r < 93)
				audio(wall_ms);
			else
				send_item(blank_item(2'($urandom), $urandom));
		end
	endtask

	function automatic logic [15:0] pick_setting(input int unsigned lo, input int unsigned hi,
		input int unsigned usual);
		int r;
		r = $urandom_range(0, 3);
		if (r == 0)
			return 16'(lo);
		else if (r == 1)
			return 16'(hi);
		return 16'($urandom_range(lo, usual));
	endfunction

	// Random phases: reset values, all low, all high, then mixed settings.
	task automatic test_random_traffic();
		for (int phase = 0; phase < 6; phase++) begin
			settle();
			if (phase == 0)
				configure(POLL_INTERVAL_RST, RECONNECT_RST, HOLD_RST, QUIET_RST,
					STABLE_READS_RST);
			else if (phase == 1)
				configure(16'd1, 16'd1, 16'd1, 16'd0, 8'd1);
			else if (phase == 2)
				configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
			else
				configure(pick_setting(1, 65535, 300), pick_setting(1, 65535, 3000),
					pick_setting(1, 65535, 1500), pick_setting(0, 65535, 3000),
					8'(pick_setting(1, 255, 4)));
			run_traffic(250);
		end
	endtask

	initial begin
		arst_n     <= 1'b0;
		item_valid <= 1'b0;
		item       <= '0;
		cfg_we     <= 1'b0;
		cfg_index  <= '0;
		cfg_data   <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reader_recovery();
		test_tag_debounce();
		test_register_extremes();
		test_long_debounce();
		test_random_traffic();
		settle();
		if (fault_count == 0 && events_due.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// A hung handshake ends the run here.
	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/nfctpq_pkg.sv
hw/rtl/nfc_tag_presence_qualifier_core.sv
hw/rtl/nfctpq_checker.sv
bench/testbench.sv
